// ===== sv/fbde_pkg.sv =====
// Shared types, constants and the glyph ROM of the frame buffer draw engine.
`default_nettype none

package fbde_pkg;

    // Command codes as they arrive on the cmd port
    typedef enum logic [2:0] {
        OP_FILL  = 3'd0,
        OP_PIXEL = 3'd1,
        OP_HLINE = 3'd2,
        OP_VLINE = 3'd3,
        OP_RECT  = 3'd4,
        OP_GLYPH = 3'd5,
        OP_READ  = 3'd6,
        OP_BAD   = 3'd7
    } op_t;

    // Executor states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_RWAIT,
        ST_GLYPH,
        ST_FILL,
        ST_DONE
    } back_state_t;

    // Classified command as it travels through the queue
    typedef struct packed {
        op_t        op;
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] xb;
        logic [7:0] yb;
        logic       color;
        logic       ok;     // position checks passed
        logic [4:0] gidx;   // glyph ROM row, blank for codes outside the ROM
    } job_t;

    // Executor status seen by the front end
    typedef struct packed {
        logic clearing;
        logic active;
    } status_t;

    localparam logic [7:0] GLYPH_BASE  = 8'h20;
    localparam int         GLYPH_W     = 6;
    localparam int         GLYPH_COUNT = 27;
    localparam logic [7:0] BYTE_ON     = 8'hFF;
    localparam logic [7:0] BYTE_OFF    = 8'h00;
    localparam int         QUEUE_DEPTH = 2;

    typedef logic [0:GLYPH_W-1][7:0] glyph_cols_t;

    // One column byte of a 6x8 glyph, column 0 first
    function automatic logic [7:0] glyph_byte(input logic [4:0] idx, input logic [2:0] col);
        glyph_cols_t row;
        logic [7:0]  res;
        case (idx)
            5'd1:    row = 48'h00005F000000;
            5'd2:    row = 48'h000700070000;
            5'd3:    row = 48'h147F147F1400;
            5'd4:    row = 48'h242A7F2A1200;
            5'd5:    row = 48'h231308646200;
            5'd6:    row = 48'h364955225000;
            5'd7:    row = 48'h000503000000;
            5'd8:    row = 48'h001C22410000;
            5'd9:    row = 48'h0041221C0000;
            5'd10:   row = 48'h082A1C2A0800;
            5'd11:   row = 48'h08083E080800;
            5'd12:   row = 48'h005030000000;
            5'd13:   row = 48'h080808080800;
            5'd14:   row = 48'h006060000000;
            5'd15:   row = 48'h201008040200;
            5'd16:   row = 48'h3E5149453E00;
            5'd17:   row = 48'h00427F400000;
            5'd18:   row = 48'h426151494600;
            5'd19:   row = 48'h2141454B3100;
            5'd20:   row = 48'h1814127F1000;
            5'd21:   row = 48'h274545453900;
            5'd22:   row = 48'h3C4A49493000;
            5'd23:   row = 48'h017109050300;
            5'd24:   row = 48'h364949493600;
            5'd25:   row = 48'h064949291E00;
            5'd26:   row = 48'h003636000000;
            default: row = 48'h000000000000;
        endcase
        if (col < 3'(GLYPH_W))
            res = row[col];
        else
            res = BYTE_OFF;
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fbde_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module fbde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== sv/fbde_front.sv =====
// Command front end: takes commands, checks positions and fills the queue.
`default_nettype none

module fbde_front import fbde_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_PAGES  = 8,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic       start,
    input  wire logic [2:0] cmd,
    input  wire logic [7:0] xa,
    input  wire logic [7:0] ya,
    input  wire logic [7:0] xb,
    input  wire logic [7:0] yb,
    input  wire logic       color,
    input  wire logic [7:0] char_code,
    input  wire logic       q_full,
    input  wire status_t    status,
    output logic            busy,
    output logic            push,
    output job_t            push_job
);

    localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] P9 = 9'(SCREEN_PAGES);
    localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);
    localparam logic [8:0] GLYPH_X_MAX = 9'(SCREEN_WIDTH - GLYPH_W);

    logic [7:0] gdelta;
    logic       pix_in;
    logic       glyph_in;
    logic       read_in;
    op_t        op;

    // No transfer while the store is being cleared or the queue is full
    assign busy = q_full | status.clearing;
    assign push = start & ~busy;

    // Range checks
    assign pix_in   = ({1'b0, xa} < W9) && ({1'b0, ya} < H9) && ({4'b0, ya[7:3]} < P9);
    assign glyph_in = ({1'b0, xa} <= GLYPH_X_MAX) && ({1'b0, ya} < P9);
    assign read_in  = ({1'b0, xa} < W9) && ({1'b0, ya} < P9);
    assign gdelta   = char_code - GLYPH_BASE;
    assign op       = op_t'(cmd);

    // Classification
    always_comb
    begin
        push_job.op    = op;
        push_job.xa    = xa;
        push_job.ya    = ya;
        push_job.xb    = xb;
        push_job.yb    = yb;
        push_job.color = color;
        push_job.gidx  = (gdelta < 8'(GLYPH_COUNT)) ? gdelta[4:0] : 5'd0;
        unique case (op)
            OP_PIXEL: push_job.ok = pix_in;
            OP_GLYPH: push_job.ok = glyph_in;
            OP_READ:  push_job.ok = read_in;
            OP_BAD:   push_job.ok = 1'b0;
            default:  push_job.ok = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/fbde_queue.sv =====
// Two-entry command queue between front end and executor.
`default_nettype none

module fbde_queue import fbde_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      q_valid,
    output logic      q_full,
    output job_t      q_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign q_job   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop & q_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== sv/fbde_back.sv =====
// Executor: draws pixels, lines, glyphs and fills, and serves reads.
`default_nettype none

module fbde_back import fbde_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_PAGES  = 8,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire job_t       q_job,
    output logic            pop,
    output status_t         status,
    output logic            done,
    output logic [7:0]      read_data,
    output logic            accepted
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [7:0] W_LAST = 8'(SCREEN_WIDTH - 1);
    localparam logic [7:0] H_LAST = 8'(SCREEN_HEIGHT - 1);
    localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] P9 = 9'(SCREEN_PAGES);
    localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);

    back_state_t   state_reg, state_next;
    job_t          job_reg, job_next;
    logic [1:0]    seg_reg, seg_next;
    logic [7:0]    cur_reg, cur_next;
    logic [7:0]    last_reg, last_next;
    logic [7:0]    fix_reg, fix_next;
    logic          vert_reg, vert_next;
    logic          lit_reg, lit_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [7:0]    rd_reg, rd_next;
    logic          ok_reg, ok_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic          use_cnt;
    logic [4:0]    a_page;
    logic [7:0]    a_x;
    logic [AW-1:0] addr_calc;

    logic [7:0]    px, py, mask;
    logic          pix_ok, at_last, last_seg;
    logic          seg_vert, seg_empty;
    logic [7:0]    seg_fix, seg_start, seg_raw, seg_limit, seg_last;

    fbde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Current pixel of the walk
    assign px      = vert_reg ? fix_reg : cur_reg;
    assign py      = vert_reg ? cur_reg : fix_reg;
    assign mask    = 8'(1) << py[2:0];
    assign pix_ok  = ({1'b0, px} < W9) && ({1'b0, py} < H9) && ({4'b0, py[7:3]} < P9);
    assign at_last = (cur_reg == last_reg);
    assign last_seg = (job_reg.op != OP_RECT) || (seg_reg == 2'd3);

    // Segment set-up: 0 top, 1 bottom, 2 left, 3 right
    assign seg_vert = seg_reg[1];
    always_comb
    begin
        case (seg_reg)
            2'd0:    seg_fix = job_reg.ya;
            2'd1:    seg_fix = job_reg.yb;
            2'd2:    seg_fix = job_reg.xa;
            default: seg_fix = job_reg.xb;
        endcase
    end
    assign seg_start = seg_vert ? job_reg.ya : job_reg.xa;
    assign seg_raw   = seg_vert ? job_reg.yb : job_reg.xb;
    assign seg_limit = seg_vert ? H_LAST : W_LAST;
    assign seg_last  = (seg_raw > seg_limit) ? seg_limit : seg_raw;
    assign seg_empty = (seg_start > seg_last);

    // Store address: page * width + column
    assign addr_calc = AW'(a_page) * AW'(SCREEN_WIDTH) + AW'(a_x);
    assign mem_addr  = use_cnt ? cnt_reg : addr_calc;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (cnt_reg == ADDR_LAST)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                    state_next = ST_SETUP;
            ST_SETUP:
                unique case (job_reg.op) inside
                    OP_FILL:
                        state_next = ST_FILL;
                    OP_PIXEL:
                        state_next = job_reg.ok ? ST_RD : ST_DONE;
                    OP_HLINE, OP_VLINE, OP_RECT:
                        if (!seg_empty)
                            state_next = ST_RD;
                        else if (last_seg)
                            state_next = ST_DONE;
                    OP_GLYPH:
                        state_next = job_reg.ok ? ST_GLYPH : ST_DONE;
                    OP_READ:
                        state_next = job_reg.ok ? ST_RWAIT : ST_DONE;
                    default:
                        state_next = ST_DONE;
                endcase
            ST_RD:
                if (pix_ok)
                    state_next = ST_WR;
                else if (at_last)
                    state_next = last_seg ? ST_DONE : ST_SETUP;
            ST_WR:
                if (at_last)
                    state_next = last_seg ? ST_DONE : ST_SETUP;
                else
                    state_next = ST_RD;
            ST_RWAIT:
                state_next = ST_DONE;
            ST_GLYPH:
                if (cnt_reg[2:0] == 3'(GLYPH_W - 1))
                    state_next = ST_DONE;
            ST_FILL:
                if (cnt_reg == ADDR_LAST)
                    state_next = ST_DONE;
            ST_DONE:
                state_next = q_valid ? ST_SETUP : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        job_next  = job_reg;
        seg_next  = seg_reg;
        cur_next  = cur_reg;
        last_next = last_reg;
        fix_next  = fix_reg;
        vert_next = vert_reg;
        lit_next  = lit_reg;
        cnt_next  = cnt_reg;
        rd_next   = rd_reg;
        ok_next   = ok_reg;
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = BYTE_OFF;
        use_cnt   = 1'b0;
        a_page    = py[7:3];
        a_x       = px;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                use_cnt  = 1'b1;
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE, ST_DONE:
                if (q_valid)
                begin
                    pop      = 1'b1;
                    job_next = q_job;
                    seg_next = (q_job.op == OP_VLINE) ? 2'd2 : 2'd0;
                    rd_next  = BYTE_OFF;
                    ok_next  = q_job.ok;
                    cnt_next = '0;
                end
            ST_SETUP:
            begin
                // read command issues its store read here
                a_page = job_reg.ya[4:0];
                a_x    = job_reg.xa;
                if (job_reg.op == OP_PIXEL)
                begin
                    vert_next = 1'b1;
                    fix_next  = job_reg.xa;
                    cur_next  = job_reg.ya;
                    last_next = job_reg.ya;
                    lit_next  = job_reg.color;
                end
                else
                begin
                    vert_next = seg_vert;
                    fix_next  = seg_fix;
                    cur_next  = seg_start;
                    last_next = seg_last;
                    lit_next  = 1'b1;
                    if (seg_empty && !last_seg)
                        seg_next = seg_reg + 1'b1;
                end
            end
            ST_RD, ST_WR:
            begin
                if (state_reg == ST_WR)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = lit_reg ? (mem_rdata | mask) : (mem_rdata & ~mask);
                end
                // step the walk after the write or past a dropped pixel
                if (state_reg == ST_WR || !pix_ok)
                begin
                    if (!at_last)
                        cur_next = cur_reg + 1'b1;
                    else if (!last_seg)
                        seg_next = seg_reg + 1'b1;
                end
            end
            ST_RWAIT:
                rd_next = mem_rdata;
            ST_GLYPH:
            begin
                a_page    = job_reg.ya[4:0];
                a_x       = job_reg.xa + 8'(cnt_reg[2:0]);
                mem_we    = 1'b1;
                mem_wdata = glyph_byte(job_reg.gidx, cnt_reg[2:0]);
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_FILL:
            begin
                use_cnt   = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = job_reg.color ? BYTE_ON : BYTE_OFF;
                cnt_next  = cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Walk and result registers
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        seg_reg  <= seg_next;
        cur_reg  <= cur_next;
        last_reg <= last_next;
        fix_reg  <= fix_next;
        vert_reg <= vert_next;
        lit_reg  <= lit_next;
        rd_reg   <= rd_next;
        ok_reg   <= ok_next;
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.active   = (state_reg != ST_IDLE) && (state_reg != ST_CLEAR);
    assign done            = (state_reg == ST_DONE);
    assign read_data       = rd_reg;
    assign accepted        = ok_reg;

endmodule

`default_nettype wire

// ===== sv/mono_framebuffer_draw_engine.sv =====
// Top level of the page-organized 1 bpp frame buffer draw engine.
`default_nettype none

// Usage
//   Commands: drive cmd, xa, ya, xb, yb, color and char_code with start high;
//   the transfer happens at a rising edge with start high and busy low.
//   Results: done is high for exactly one cycle with read_data and accepted;
//   the receiver cannot stall, so every result must be taken in that cycle.
//   A two-entry queue lets new commands in while the executor is working.
//   The executor uses a single-port store: pixels, lines and rectangles are
//   drawn by read-modify-write, glyphs and fills write whole bytes, and
//   off-screen line pixels and out-of-range pixel, glyph or read commands
//   are skipped.
//   Reset: after rst_n rises the store is cleared one byte per cycle,
//   all SCREEN_WIDTH*SCREEN_PAGES bytes (1024 by default); busy is high all
//   that time and no command is taken.

module mono_framebuffer_draw_engine import fbde_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_PAGES  = 8,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] cmd,
    input  wire logic [7:0] xa,
    input  wire logic [7:0] ya,
    input  wire logic [7:0] xb,
    input  wire logic [7:0] yb,
    input  wire logic       color,
    input  wire logic [7:0] char_code,
    output logic            done,
    output logic [7:0]      read_data,
    output logic            accepted
);

    logic    push;
    job_t    push_job;
    logic    pop;
    logic    q_valid;
    logic    q_full;
    job_t    q_job;
    status_t status;

    fbde_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_PAGES  (SCREEN_PAGES),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .start     (start),
        .cmd       (cmd),
        .xa        (xa),
        .ya        (ya),
        .xb        (xb),
        .yb        (yb),
        .color     (color),
        .char_code (char_code),
        .q_full    (q_full),
        .status    (status),
        .busy      (busy),
        .push      (push),
        .push_job  (push_job)
    );

    fbde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_job    (q_job)
    );

    fbde_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_PAGES  (SCREEN_PAGES),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .status    (status),
        .done      (done),
        .read_data (read_data),
        .accepted  (accepted)
    );

    // No result while the store is still being cleared
    a_no_done_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !done)
        else $error("result strobe during clearing pass");

    // A transfer always leaves a queued command behind
    a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("transferred command lost in queue");

    // Nonzero read data only comes from a read that was carried out
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_data != 8'h00) |-> accepted)
        else $error("read data on a rejected command");

    // Executor only pops when it holds no work
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (done || !status.active) && !status.clearing)
        else $error("queue popped while executor busy");

endmodule

`default_nettype wire
